// ===== rtl/json_string_unescape_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BUSY      = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_NO_QUOTE  = 2'd2,
        ST_EARLY_END = 2'd3
    } t_status;

    // Most result words one input word can cause (3 UTF-8 bytes + status)
    localparam int unsigned RUN_DEPTH = 4;
    localparam int unsigned RUN_IDX_W = $clog2(RUN_DEPTH);
    localparam int unsigned RUN_CNT_W = $clog2(RUN_DEPTH + 1);

    // UTF-8 encoding constants
    localparam logic [7:0]  C_LEAD2     = 8'hC0;
    localparam logic [7:0]  C_LEAD3     = 8'hE0;
    localparam logic [7:0]  C_CONT      = 8'h80;
    localparam logic [5:0]  C_LOW6_MASK = 6'h3F;
    localparam logic [15:0] C_ONE_LIM   = 16'h0080;
    localparam logic [15:0] C_TWO_LIM   = 16'h0800;

    // One result word
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        t_status    status;
        logic       last;
    } t_res;

    // All result words caused by one input word
    typedef struct packed {
        t_res [RUN_DEPTH-1:0] res;
        logic [RUN_CNT_W-1:0] cnt;
    } t_run;

endpackage

// ===== rtl/jsu_decoder.sv =====
module jsu_decoder
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_run       o_run
);

    typedef enum logic [4:0] {
        PH_SEEK = 5'b00001,
        PH_BODY = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_HEX  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_seen, n_seen;
    logic        r_stop, n_stop;

    logic [4:0]  w_digit;
    logic [15:0] w_code;
    t_run        w_run;

    // hex digit lookup: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    function automatic t_res mk(input logic [7:0] d, input logic v, input t_status s);
        t_res e;
        e.data       = d;
        e.byte_valid = v;
        e.status     = s;
        e.last       = 1'b0;
        return e;
    endfunction

    function automatic t_run push(input t_run r, input t_res e);
        t_run q;
        q = r;
        q.res[r.cnt[RUN_IDX_W-1:0]] = e;
        q.cnt = r.cnt + RUN_CNT_W'(1);
        return q;
    endfunction

    assign w_digit = hex_digit(i_byte);

    // decode one word: next state and its result words
    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_seen  = r_seen;
        n_stop  = r_stop;
        w_run   = '0;
        w_code  = r_hex;

        unique case (r_phase)
            PH_SEEK: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_BODY;
                end else if (i_byte == CH_SPACE || i_byte == CH_TAB ||
                             i_byte == CH_LF || i_byte == CH_CR) begin
                    if (i_eot) begin
                        w_run   = push(w_run, mk(8'd0, 1'b0, ST_NO_QUOTE));
                        n_phase = PH_DONE;
                    end
                end else begin
                    w_run   = push(w_run, mk(8'd0, 1'b0, ST_NO_QUOTE));
                    n_phase = PH_DONE;
                end
            end
            PH_BODY: begin
                if (i_byte == CH_QUOTE) begin
                    w_run   = push(w_run, mk(8'd0, 1'b0, ST_COMPLETE));
                    n_phase = PH_DONE;
                end else if (i_byte == CH_BSL) begin
                    n_phase = PH_ESC;
                end else begin
                    w_run = push(w_run, mk(i_byte, 1'b1, ST_BUSY));
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                case (i_byte)
                    CH_N:    w_run = push(w_run, mk(CH_LF, 1'b1, ST_BUSY));
                    CH_T:    w_run = push(w_run, mk(CH_TAB, 1'b1, ST_BUSY));
                    CH_R:    w_run = push(w_run, mk(CH_CR, 1'b1, ST_BUSY));
                    CH_B:    w_run = push(w_run, mk(CH_BS, 1'b1, ST_BUSY));
                    CH_F:    w_run = push(w_run, mk(CH_FF, 1'b1, ST_BUSY));
                    CH_U: begin
                        n_phase = PH_HEX;
                        n_hex   = '0;
                        n_seen  = '0;
                        n_stop  = 1'b0;
                    end
                    default: w_run = push(w_run, mk(i_byte, 1'b1, ST_BUSY));
                endcase
            end
            PH_HEX: begin
                // digits after the first non-hex byte add nothing
                if (!r_stop && w_digit[4]) begin
                    w_code = {r_hex[11:0], w_digit[3:0]};
                end else begin
                    n_stop = 1'b1;
                end
                n_hex = w_code;
                if (r_seen == 2'd3) begin
                    if (w_code < C_ONE_LIM) begin
                        w_run = push(w_run, mk(w_code[7:0], 1'b1, ST_BUSY));
                    end else if (w_code < C_TWO_LIM) begin
                        w_run = push(w_run, mk(C_LEAD2 | {3'd0, w_code[10:6]},
                                               1'b1, ST_BUSY));
                        w_run = push(w_run, mk(C_CONT | {2'd0, w_code[5:0] & C_LOW6_MASK},
                                               1'b1, ST_BUSY));
                    end else begin
                        w_run = push(w_run, mk(C_LEAD3 | {4'd0, w_code[15:12]},
                                               1'b1, ST_BUSY));
                        w_run = push(w_run, mk(C_CONT | {2'd0, w_code[11:6] & C_LOW6_MASK},
                                               1'b1, ST_BUSY));
                        w_run = push(w_run, mk(C_CONT | {2'd0, w_code[5:0] & C_LOW6_MASK},
                                               1'b1, ST_BUSY));
                    end
                    n_phase = PH_BODY;
                    n_hex   = '0;
                    n_seen  = '0;
                    n_stop  = 1'b0;
                end else begin
                    n_seen = r_seen + 2'd1;
                end
            end
            default: begin
                // finished: swallow everything
                n_phase = PH_DONE;
            end
        endcase

        // text ended before the string closed
        if (r_phase != PH_DONE && i_eot && n_phase != PH_DONE) begin
            w_run   = push(w_run, mk(8'd0, 1'b0, ST_EARLY_END));
            n_phase = PH_DONE;
        end

        if (w_run.cnt != '0) begin
            w_run.res[RUN_IDX_W'(w_run.cnt - RUN_CNT_W'(1))].last = 1'b1;
        end
    end

    assign o_run = w_run;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_hex   <= '0;
            r_seen  <= '0;
            r_stop  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_seen  <= n_seen;
            r_stop  <= n_stop;
        end
    end

endmodule

// ===== rtl/jsu_run_buf.sv =====
module jsu_run_buf
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_run i_run,
    input  logic i_take,
    output logic o_valid,
    output logic o_last_pending,
    output t_res o_res
);

    t_res [RUN_DEPTH-1:0] r_buf;
    logic [RUN_IDX_W-1:0] r_head;
    logic [RUN_CNT_W-1:0] r_left;

    assign o_valid        = (r_left != '0);
    assign o_last_pending = (r_left == RUN_CNT_W'(1));
    assign o_res          = r_buf[r_head];

    // words left in the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_left <= '0;
        end else if (i_load) begin
            r_head <= '0;
            r_left <= i_run.cnt;
        end else if (i_take && o_valid) begin
            r_head <= r_head + RUN_IDX_W'(1);
            r_left <= r_left - RUN_CNT_W'(1);
        end
    end

    // run payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_run.res;
        end
    end

endmodule

// ===== rtl/json_string_unescape_core.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_end_of_text
// out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_byte_valid,
//         |           |                            | o_status, o_last_of_run
//
// One input word per cycle while the run buffer can take its run; each word
// gives 0 to 4 output words, sent one per cycle from a run buffer while i_out_ready.
// A word is held in the input register, then decoded into the run buffer.
// The run buffer loads a new run when it is empty or its last word leaves.
// Reset (synchronous, active low) returns to seeking the opening quote.
module json_string_unescape_core
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic [1:0] o_status,
    output logic       o_last_of_run
);

    logic       r_iv;
    logic [7:0] r_in_byte;
    logic       r_in_eot;

    logic w_adv;
    logic w_buf_valid;
    logic w_buf_last;
    t_run w_run;
    t_res w_res;

    // decode the held word once the run buffer frees up
    assign w_adv      = r_iv && (!w_buf_valid || (w_buf_last && i_out_ready));
    assign o_in_ready = !r_iv || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (o_in_ready) begin
            r_iv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    jsu_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_run   (w_run)
    );

    jsu_run_buf u_buf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_adv),
        .i_run          (w_run),
        .i_take         (i_out_ready),
        .o_valid        (w_buf_valid),
        .o_last_pending (w_buf_last),
        .o_res          (w_res)
    );

    assign o_out_valid   = w_buf_valid;
    assign o_out_byte    = w_res.data;
    assign o_byte_valid  = w_res.byte_valid;
    assign o_status      = w_res.status;
    assign o_last_of_run = w_res.last;

endmodule

// ===== rtl/jsu_checker.sv =====
`include "json_string_unescape_core_macros.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic [1:0] o_status,
    input logic       o_last_of_run
);

    // a stalled output word stays offered
    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_byte) && $stable(o_status),
        "output word dropped while stalled")

    // a status word carries no byte and closes its run
    `JSU_ASSERT_NOW(a_status_alone, i_clk, i_rst_n, o_out_valid && (o_status != ST_BUSY),
        !o_byte_valid && (o_out_byte == 8'd0) && o_last_of_run,
        "status word not alone")

    // every word carries either a byte or a status
    `JSU_ASSERT_NOW(a_word_kind, i_clk, i_rst_n, o_out_valid && !o_byte_valid,
        o_status != ST_BUSY, "empty output word")

    // nothing follows the final status
    `JSU_ASSERT_NEXT(a_quiet_after_end, i_clk, i_rst_n,
        o_out_valid && i_out_ready && (o_status != ST_BUSY), !o_out_valid,
        "output after final status")

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (.*);

// ===== bench/json_string_unescape_core_test.sv =====
module json_string_unescape_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // ASCII codes the decoder reacts to, and other stimulus bytes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] ESC_B     = 8'h62;
    localparam logic [7:0] ESC_F     = 8'h66;
    localparam logic [7:0] ESC_N     = 8'h6E;
    localparam logic [7:0] ESC_R     = 8'h72;
    localparam logic [7:0] ESC_T     = 8'h74;
    localparam logic [7:0] ESC_U     = 8'h75;

    localparam int unsigned RAND_WORDS  = 120;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned HOLD_AT     = 70;
    localparam int unsigned HOLD_LEN    = 80;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_SEEK,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_DONE
    } t_phase;

    // How a stimulus row is checked: by the decoder model, or by a typed result
    typedef enum logic [1:0] {
        ROW_FREE,
        ROW_QUIET,
        ROW_ONE
    } t_row_kind;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        t_row_kind  kind;
        logic [7:0] exp_b;
    } t_text_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic [1:0] o_status;
    logic       o_last_of_run;

    // Row kind and typed byte travel alongside the word on the input port
    t_row_kind  row_kind = ROW_FREE;
    logic [7:0] row_exp  = 8'h00;

    t_text_row   text_q[$];
    t_res        run_words[$];
    t_res        due_words[$];
    bit          no_quote_run;
    int unsigned mismatches = 0;
    int unsigned in_words   = 0;
    int unsigned text_idx   = 0;
    int unsigned quiet      = 0;

    // Decoder model state
    t_phase      dec_phase  = PH_SEEK;
    logic [15:0] code_acc   = 16'h0000;
    logic [1:0]  hex_cnt    = 2'd0;
    logic        hex_halt   = 1'b0;

    json_string_unescape_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_row(input logic [7:0] b, input logic eot, input t_row_kind kind,
                           input logic [7:0] exp_b);
        t_text_row r;
        r.b     = b;
        r.eot   = eot;
        // typed results assume the string really opened
        r.kind  = no_quote_run ? ROW_FREE : kind;
        r.exp_b = exp_b;
        text_q = {text_q, r};
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    task automatic put_word(input logic [7:0] data, input logic vld, input t_status st);
        t_res w;
        w.data       = data;
        w.byte_valid = vld;
        w.status     = st;
        w.last       = 1'b0;
        run_words = {run_words, w};
    endtask

    // Decoder model: words caused by one text byte land in run_words
    task automatic unescape_byte(input logic [7:0] b, input logic eot);
        logic       is_hex;
        logic [3:0] nib;
        is_hex = 1'b1;
        nib    = b[3:0];
        if (b >= 8'h30 && b <= 8'h39)
            nib = b[3:0];
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            nib = b[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        run_words.delete();
        case (dec_phase)
            PH_SEEK: begin
                if (b == CH_QUOTE) begin
                    dec_phase = PH_BODY;
                end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                    if (eot) begin
                        put_word(8'h00, 1'b0, ST_NO_QUOTE);
                        dec_phase = PH_DONE;
                    end
                end else begin
                    put_word(8'h00, 1'b0, ST_NO_QUOTE);
                    dec_phase = PH_DONE;
                end
            end
            PH_BODY: begin
                if (b == CH_QUOTE) begin
                    put_word(8'h00, 1'b0, ST_COMPLETE);
                    dec_phase = PH_DONE;
                end else if (b == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    put_word(b, 1'b1, ST_BUSY);
                end
            end
            PH_ESC: begin
                dec_phase = PH_BODY;
                case (b)
                    ESC_N: put_word(CH_LF, 1'b1, ST_BUSY);
                    ESC_T: put_word(CH_TAB, 1'b1, ST_BUSY);
                    ESC_R: put_word(CH_CR, 1'b1, ST_BUSY);
                    ESC_B: put_word(CH_BS, 1'b1, ST_BUSY);
                    ESC_F: put_word(CH_FF, 1'b1, ST_BUSY);
                    ESC_U: begin
                        dec_phase = PH_HEX;
                        code_acc  = 16'h0000;
                        hex_cnt   = 2'd0;
                        hex_halt  = 1'b0;
                    end
                    default: put_word(b, 1'b1, ST_BUSY);
                endcase
            end
            PH_HEX: begin
                // digits stop counting at the first non-hex byte
                if (!hex_halt && is_hex)
                    code_acc = {code_acc[11:0], nib};
                else
                    hex_halt = 1'b1;
                if (hex_cnt == 2'd3) begin
                    if (code_acc < C_ONE_LIM) begin
                        put_word(code_acc[7:0], 1'b1, ST_BUSY);
                    end else if (code_acc < C_TWO_LIM) begin
                        put_word(C_LEAD2 | {3'b000, code_acc[10:6]}, 1'b1, ST_BUSY);
                        put_word(C_CONT | {2'b00, code_acc[5:0]}, 1'b1, ST_BUSY);
                    end else begin
                        put_word(C_LEAD3 | {4'h0, code_acc[15:12]}, 1'b1, ST_BUSY);
                        put_word(C_CONT | {2'b00, code_acc[11:6]}, 1'b1, ST_BUSY);
                        put_word(C_CONT | {2'b00, code_acc[5:0]}, 1'b1, ST_BUSY);
                    end
                    dec_phase = PH_BODY;
                    code_acc  = 16'h0000;
                    hex_cnt   = 2'd0;
                    hex_halt  = 1'b0;
                end else begin
                    hex_cnt = hex_cnt + 2'd1;
                end
            end
            default: dec_phase = PH_DONE;
        endcase

        if (eot && dec_phase != PH_DONE) begin
            put_word(8'h00, 1'b0, ST_EARLY_END);
            dec_phase = PH_DONE;
        end
    endtask

    // Sender: walks the text in bursts with random gaps
    always @(posedge i_clk) begin : sender
        int unsigned burst_left;
        int unsigned gap_left;
        t_text_row   r;
        bit          took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            text_idx   = 0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took)
                text_idx = text_idx + 1;
            if (i_in_valid && !took) begin
                // hold the word until it is taken
            end else if (text_idx >= text_q.size()) begin
                i_in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left   = gap_left - 1;
                i_in_valid <= 1'b0;
            end else begin
                r = text_q[text_idx];
                i_in_byte     <= r.b;
                i_end_of_text <= r.eot;
                row_kind      <= r.kind;
                row_exp       <= r.exp_b;
                i_in_valid    <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left = burst_left - 1;
                end
            end
        end
    end

    // Receiver: rotating stall pattern, plus one long hold-off
    always @(posedge i_clk) begin : receiver
        logic [7:0]  rdy_pat;
        int unsigned pat_age;
        int unsigned hold_left;
        bit          hold_used;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rdy_pat     = 8'hFF;
            pat_age     = 0;
            hold_left   = 0;
            hold_used   = 1'b0;
        end else if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_used && in_words >= HOLD_AT) begin
            hold_used   = 1'b1;
            hold_left   = HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       rdy_pat = 8'hFF;
                    1:       rdy_pat = 8'hB6;
                    2:       rdy_pat = 8'h5A;
                    default: rdy_pat = 8'($urandom);
                endcase
                pat_age = 24;
            end
            pat_age     = pat_age - 1;
            i_out_ready <= rdy_pat[0];
            rdy_pat     = {rdy_pat[0], rdy_pat[7:1]};
        end
    end

    // Scoreboard: predict on input accept, compare on output accept
    always @(posedge i_clk) begin : scoreboard
        t_res w;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_words <= in_words + 1;
                unescape_byte(i_in_byte, i_end_of_text);
                if (row_kind != ROW_FREE) begin
                    run_words.delete();
                    if (row_kind == ROW_ONE)
                        put_word(row_exp, 1'b1, ST_BUSY);
                end
                if (run_words.size() > 0) begin
                    w = run_words.pop_back();
                    w.last = 1'b1;
                    run_words = {run_words, w};
                end
                due_words = {due_words, run_words};
                run_words.delete();
            end
            if (o_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word %02h", o_out_byte));
                end else begin
                    w = due_words.pop_front();
                    if (o_out_byte !== w.data)
                        flag_mismatch($sformatf("out_byte %02h, want %02h", o_out_byte, w.data));
                    if (o_byte_valid !== w.byte_valid)
                        flag_mismatch($sformatf("byte_valid %b, want %b",
                                                o_byte_valid, w.byte_valid));
                    if (o_status !== w.status)
                        flag_mismatch($sformatf("status %0d, want %0d", o_status, w.status));
                    if (o_last_of_run !== w.last)
                        flag_mismatch($sformatf("last_of_run %b, want %b",
                                                o_last_of_run, w.last));
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic [7:0]  b;
        logic [15:0] cp;
        int unsigned base;
        int unsigned k;

        // an occasional run never opens the string
        no_quote_run = ($urandom_range(0, 5) == 0);

        // Directed: whitespace, open, extremes, escapes n t r b f and quote, 3-byte \u
        add_row(CH_SPACE, 1'b0, ROW_QUIET, 8'h00);
        add_row(CH_TAB, 1'b0, ROW_QUIET, 8'h00);
        add_row(CH_CR, 1'b0, ROW_QUIET, 8'h00);
        add_row(CH_LF, 1'b0, ROW_QUIET, 8'h00);
        if (!no_quote_run) begin
            add_row(CH_QUOTE, 1'b0, ROW_QUIET, 8'h00);
        end else if ($urandom_range(0, 1)) begin
            add_row(CH_SPACE, 1'b1, ROW_FREE, 8'h00);
        end else begin
            b = 8'($urandom);
            if (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
                b = CH_X;
            add_row(b, 1'b0, ROW_FREE, 8'h00);
        end
        add_row(8'h41, 1'b0, ROW_ONE, 8'h41);
        add_row(8'h00, 1'b0, ROW_ONE, 8'h00);
        add_row(8'hFF, 1'b0, ROW_ONE, 8'hFF);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_N, 1'b0, ROW_ONE, CH_LF);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_T, 1'b0, ROW_ONE, CH_TAB);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_R, 1'b0, ROW_ONE, CH_CR);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_B, 1'b0, ROW_ONE, CH_BS);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_F, 1'b0, ROW_ONE, CH_FF);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(CH_QUOTE, 1'b0, ROW_ONE, CH_QUOTE);
        add_row(CH_BSLASH, 1'b0, ROW_QUIET, 8'h00);
        add_row(ESC_U, 1'b0, ROW_QUIET, 8'h00);
        add_row(8'h32, 1'b0, ROW_QUIET, 8'h00);
        add_row(8'h30, 1'b0, ROW_QUIET, 8'h00);
        add_row(8'h41, 1'b0, ROW_QUIET, 8'h00);
        add_row(8'h43, 1'b0, ROW_FREE, 8'h00);

        // Random body: plain bytes, escapes and \u sequences; no bare quote
        base = text_q.size();
        while (text_q.size() < base + RAND_WORDS) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                b = 8'($urandom);
                if (b == CH_QUOTE || b == CH_BSLASH)
                    b = b ^ 8'h80;
                add_row(b, 1'b0, ROW_FREE, 8'h00);
            end else if (k < 60) begin
                add_row(CH_BSLASH, 1'b0, ROW_FREE, 8'h00);
                case ($urandom_range(0, 8))
                    0:       b = ESC_N;
                    1:       b = ESC_T;
                    2:       b = ESC_R;
                    3:       b = ESC_B;
                    4:       b = ESC_F;
                    5:       b = CH_QUOTE;
                    6:       b = CH_BSLASH;
                    7:       b = CH_SLASH;
                    default: begin
                        b = 8'($urandom);
                        if (b == ESC_U)
                            b = b ^ 8'h80;
                    end
                endcase
                add_row(b, 1'b0, ROW_FREE, 8'h00);
            end else begin
                add_row(CH_BSLASH, 1'b0, ROW_FREE, 8'h00);
                add_row(ESC_U, 1'b0, ROW_FREE, 8'h00);
                if ($urandom_range(0, 9) < 6) begin
                    // four clean digits, often on a UTF-8 length boundary
                    case ($urandom_range(0, 7))
                        0:       cp = 16'h0000;
                        1:       cp = 16'h007F;
                        2:       cp = 16'h0080;
                        3:       cp = 16'h07FF;
                        4:       cp = 16'h0800;
                        5:       cp = 16'hFFFF;
                        default: cp = 16'($urandom);
                    endcase
                    for (int i = 3; i >= 0; i--)
                        add_row(hex_char(cp[i*4 +: 4]), 1'b0, ROW_FREE, 8'h00);
                end else begin
                    // digits mixed with sign, space, 0x, quote and junk
                    for (int i = 0; i < 4; i++) begin
                        if ($urandom_range(0, 9) < 5) begin
                            b = hex_char(4'($urandom));
                        end else begin
                            case ($urandom_range(0, 5))
                                0:       b = CH_PLUS;
                                1:       b = CH_MINUS;
                                2:       b = CH_SPACE;
                                3:       b = CH_X;
                                4:       b = CH_QUOTE;
                                default: b = 8'($urandom);
                            endcase
                        end
                        add_row(b, 1'b0, ROW_FREE, 8'h00);
                    end
                end
            end
        end

        // Ending: close, or run out of text somewhere inside the string
        case ($urandom_range(0, 5))
            0: add_row(CH_QUOTE, 1'b0, ROW_FREE, 8'h00);
            1: add_row(CH_QUOTE, 1'b1, ROW_FREE, 8'h00);
            2: begin
                b = 8'($urandom);
                if (b == CH_QUOTE || b == CH_BSLASH)
                    b = b ^ 8'h80;
                add_row(b, 1'b1, ROW_FREE, 8'h00);
            end
            3: begin
                add_row(CH_BSLASH, 1'b0, ROW_FREE, 8'h00);
                add_row($urandom_range(0, 1) ? ESC_N : CH_BSLASH, 1'b1, ROW_FREE, 8'h00);
            end
            4: begin
                add_row(CH_BSLASH, 1'b0, ROW_FREE, 8'h00);
                k = $urandom_range(0, 3);
                add_row(ESC_U, (k == 0), ROW_FREE, 8'h00);
                for (int i = 1; i <= int'(k); i++)
                    add_row(hex_char(4'($urandom)), (i == int'(k)), ROW_FREE, 8'h00);
            end
            default: begin
                // full-width code point plus the early end: most words per byte
                add_row(CH_BSLASH, 1'b0, ROW_FREE, 8'h00);
                add_row(ESC_U, 1'b0, ROW_FREE, 8'h00);
                for (int i = 0; i < 4; i++)
                    add_row(hex_char(4'hF), (i == 3), ROW_FREE, 8'h00);
            end
        endcase

        // bytes after the end are ignored
        for (int i = 0; i < 6; i++)
            add_row(8'($urandom), 1'($urandom_range(0, 1)), ROW_FREE, 8'h00);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (!(text_idx >= text_q.size() && !i_in_valid && due_words.size() == 0));
        repeat (20) @(negedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
